[sv/ptlc_pkg.sv]
// Shared types, constants and functions for the pedestrian traffic light controller.
package ptlc_pkg;

  localparam int unsigned SecW    = 8;
  localparam int unsigned CfgIdxW = 8;

  localparam logic [SecW-1:0] SecReset = SecW'(5);

  typedef enum logic [CfgIdxW-1:0] {
    REG_GREEN = 8'd0,
    REG_RED   = 8'd1,
    REG_BLINK = 8'd2,
    REG_WALK  = 8'd3
  } cfg_reg_e;

  typedef enum logic [3:0] {
    PH_GREEN   = 4'd0,
    PH_YEL1    = 4'd1,
    PH_RED     = 4'd2,
    PH_YEL2    = 4'd3,
    PH_HOLD_G  = 4'd4,
    PH_HOLD_Y  = 4'd5,
    PH_PBLINK1 = 4'd6,
    PH_WALK    = 4'd7,
    PH_PBLINK2 = 4'd8
  } phase_e;

  typedef struct packed {
    logic [SecW-1:0] green;
    logic [SecW-1:0] red;
    logic [SecW-1:0] blink;
    logic [SecW-1:0] walk;
  } cfg_t;

  typedef struct packed {
    logic car_green;
    logic car_yellow;
    logic car_red;
    logic walk_green;
    logic walk_yellow;
    logic walk_red;
  } lamps_t;

  function automatic logic [SecW-1:0] phase_duration(phase_e ph, cfg_t cfg);
    logic [SecW-1:0] dur;
    case (ph)
      PH_GREEN:   dur = cfg.green;
      PH_RED:     dur = cfg.red;
      PH_YEL1,
      PH_YEL2,
      PH_PBLINK1,
      PH_PBLINK2: dur = cfg.blink;
      default:    dur = cfg.walk;
    endcase
    return dur;
  endfunction

  function automatic logic is_blinking(phase_e ph);
    return (ph == PH_YEL1) || (ph == PH_YEL2) || (ph == PH_PBLINK1) || (ph == PH_PBLINK2);
  endfunction

  function automatic phase_e next_phase(phase_e ph);
    phase_e nxt;
    case (ph)
      PH_GREEN:   nxt = PH_YEL1;
      PH_YEL1:    nxt = PH_RED;
      PH_RED:     nxt = PH_YEL2;
      PH_HOLD_G,
      PH_HOLD_Y:  nxt = PH_PBLINK1;
      PH_PBLINK1: nxt = PH_WALK;
      PH_WALK:    nxt = PH_PBLINK2;
      default:    nxt = PH_GREEN;
    endcase
    return nxt;
  endfunction

  function automatic lamps_t decode_lamps(phase_e ph, logic blink);
    lamps_t l;
    l = '0;
    case (ph)
      PH_GREEN,
      PH_HOLD_G: begin
        l.car_green = 1'b1;
        l.walk_red  = 1'b1;
      end
      PH_YEL1,
      PH_YEL2,
      PH_HOLD_Y: begin
        l.car_yellow = blink;
        l.walk_red   = 1'b1;
      end
      PH_RED: begin
        l.car_red  = 1'b1;
        l.walk_red = 1'b1;
      end
      PH_PBLINK1: begin
        l.car_yellow  = blink;
        l.walk_yellow = blink;
      end
      PH_WALK: begin
        l.car_red    = 1'b1;
        l.walk_green = 1'b1;
      end
      PH_PBLINK2: begin
        l.car_yellow  = blink;
        l.walk_yellow = blink;
        l.walk_green  = 1'b1;
      end
      default: l = '0;
    endcase
    return l;
  endfunction

endpackage

[sv/ptlc_phase.sv]
// Phase state machine: phase, seconds counter and blink level, with lamp decode.
module ptlc_phase (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  logic            tick_i,
  input  logic            press_i,
  input  ptlc_pkg::cfg_t  cfg_i,
  output ptlc_pkg::lamps_t lamps_o
);
  import ptlc_pkg::*;

  phase_e          phase_q, phase_d;
  logic [SecW-1:0] secs_q, secs_d;
  logic            blink_q, blink_d;
  logic            moved;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_GREEN;
      secs_q  <= SecReset;
      blink_q <= 1'b1;
    end else if (step_i) begin
      phase_q <= phase_d;
      secs_q  <= secs_d;
      blink_q <= blink_d;
    end
  end

  always_comb begin
    phase_d = phase_q;
    secs_d  = secs_q;
    blink_d = blink_q;
    moved   = 1'b0;
    if (press_i) begin
      case (phase_q)
        PH_GREEN: begin
          phase_d = PH_HOLD_G;
          secs_d  = phase_duration(PH_HOLD_G, cfg_i);
          blink_d = 1'b1;
          moved   = 1'b1;
        end
        PH_YEL1,
        PH_YEL2: begin
          // yellow level frozen through the hold
          phase_d = PH_HOLD_Y;
          secs_d  = phase_duration(PH_HOLD_Y, cfg_i);
          moved   = 1'b1;
        end
        PH_RED: begin
          phase_d = PH_WALK;
          secs_d  = phase_duration(PH_WALK, cfg_i);
          blink_d = 1'b1;
          moved   = 1'b1;
        end
        default: moved = 1'b0;
      endcase
    end
    if (tick_i && !moved) begin
      if (secs_q <= SecW'(1)) begin
        phase_d = next_phase(phase_q);
        secs_d  = phase_duration(next_phase(phase_q), cfg_i);
        blink_d = 1'b1;
      end else begin
        secs_d = secs_q - SecW'(1);
        if (is_blinking(phase_q)) begin
          blink_d = ~blink_q;
        end
      end
    end
  end

  assign lamps_o = decode_lamps(phase_d, blink_d);

  a_hold_keeps_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && press_i && (phase_q == PH_YEL1 || phase_q == PH_YEL2)
    |=> phase_q == PH_HOLD_Y && blink_q == $past(blink_q))
    else $error("hold after yellow lost blink level");

  a_walk_needs_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && phase_q == PH_RED && phase_d == PH_WALK |-> press_i)
    else $error("walk entered from red without a press");

  a_no_step_no_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(phase_q) && $stable(secs_q) && $stable(blink_q))
    else $error("state changed without an item");

endmodule

[sv/pedestrian_traffic_light_controller_core.sv]
// Top level: configuration registers, item handshake and lamp result register.
// The lamps of an item are registered and appear in the cycle after the item is accepted.
// Throughput: one item per cycle; a stalled result holds off the next item until it is taken.
// Reset: phase car green, counter and durations 5 s, blink level on, no result pending.
// Configuration writes are taken every cycle and apply on the next phase entry.
module pedestrian_traffic_light_controller_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [ptlc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [ptlc_pkg::SecW-1:0] cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      second_tick_i,
  input  logic                      button_press_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      car_green_o,
  output logic                      car_yellow_o,
  output logic                      car_red_o,
  output logic                      walk_green_o,
  output logic                      walk_yellow_o,
  output logic                      walk_red_o
);
  import ptlc_pkg::*;

  cfg_t   cfg_q;
  lamps_t lamps_d, lamps_q;
  logic   out_valid_q;
  logic   in_fire;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{green: SecReset, red: SecReset, blink: SecReset, walk: SecReset};
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_GREEN: cfg_q.green <= cfg_data_i;
        REG_RED:   cfg_q.red   <= cfg_data_i;
        REG_BLINK: cfg_q.blink <= cfg_data_i;
        REG_WALK:  cfg_q.walk  <= cfg_data_i;
        default:   cfg_q       <= cfg_q;
      endcase
    end
  end

  ptlc_phase u_phase (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (in_fire),
    .tick_i  (second_tick_i),
    .press_i (button_press_i),
    .cfg_i   (cfg_q),
    .lamps_o (lamps_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      lamps_q <= lamps_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign car_green_o   = lamps_q.car_green;
  assign car_yellow_o  = lamps_q.car_yellow;
  assign car_red_o     = lamps_q.car_red;
  assign walk_green_o  = lamps_q.walk_green;
  assign walk_yellow_o = lamps_q.walk_yellow;
  assign walk_red_o    = lamps_q.walk_red;

  a_item_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_o)
    else $error("accepted item produced no result");

  a_no_spurious_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_fire && (!out_valid_o || out_ready_i) |=> !out_valid_o)
    else $error("result without an item");

  a_car_walk_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && walk_green_o |-> !car_green_o && !walk_red_o)
    else $error("pedestrian green with conflicting lamps");

  a_car_single_colour: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(car_green_o && car_red_o))
    else $error("car green and red both lit");

endmodule
